// ===== design/erate_pkg.sv =====
package erate_pkg;

    localparam int IN_TDATA_W  = 96;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 232;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 32;

    localparam int DIV_W      = 44;
    localparam int DIV_ITER   = DIV_W / 2;
    localparam int DIV_CNT_W  = $clog2(DIV_ITER + 1);

    localparam logic [1:0] MODE_SAMPLE      = 2'd0;
    localparam logic [1:0] MODE_SET_VIRTUAL = 2'd1;

    localparam logic [CFG_INDEX_W-1:0] REG_VIRTUAL_ENABLE = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ZERO_OFFSET    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_STALE_WARN     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_STALE_FAULT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_WARN     = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_FAULT    = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_WARN     = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_ACCEL_FAULT    = 3'd7;

    localparam logic [31:0] STALE_WARN_RST  = 32'd20;
    localparam logic [31:0] STALE_FAULT_RST = 32'd100;
    localparam logic [30:0] SPEED_WARN_RST  = 31'd100000;
    localparam logic [30:0] SPEED_FAULT_RST = 31'd200000;
    localparam logic [30:0] ACCEL_WARN_RST  = 31'd10000000;
    localparam logic [30:0] ACCEL_FAULT_RST = 31'd20000000;

    typedef struct packed {
        logic [15:0]        raw;
        logic signed [31:0] delta;
        logic [47:0]        accum;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
        logic [31:0]        stamp;
        logic               sampled;
    } chan_t;

    typedef struct packed {
        logic load_in;
        logic prep;
        logic div_start;
        logic div_sel_acc;
        logic cap_vel;
        logic commit;
        logic report;
    } ctrl_cmd_t;

    typedef struct packed {
        logic need_update;
        logic div_done;
        logic out_free;
    } ctrl_sts_t;

    // x * 1000 as shifts: 1024 - 16 - 8
    function automatic logic signed [DIV_W-1:0] mul1000(input logic signed [DIV_W-1:0] x);
        return (x <<< 10) - (x <<< 4) - (x <<< 3);
    endfunction

endpackage

// ===== design/erate_div.sv =====
module erate_div #(
    parameter int DT_W = 7
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    input  logic signed [erate_pkg::DIV_W-1:0]    dividend,
    input  logic [DT_W-1:0]                       divisor,
    output logic                                  busy,
    output logic                                  done,
    output logic signed [31:0]                    quot
);
    import erate_pkg::*;

    logic                  busy_reg;
    logic                  done_reg;
    logic [DIV_CNT_W-1:0]  cnt_reg;
    logic                  neg_reg;
    logic [DIV_W-1:0]      num_reg;
    logic [DT_W-1:0]       rem_reg;
    logic [DT_W-1:0]       den_reg;
    logic signed [31:0]    quot_reg;

    logic [DIV_W-1:0]      mag;
    logic [DT_W:0]         r1;
    logic [DT_W:0]         r2;
    logic                  ge1;
    logic                  ge2;
    logic [DT_W-1:0]       r1_next;
    logic [DT_W-1:0]       rem_next;
    logic [DIV_W-1:0]      num_next;
    logic signed [31:0]    quot_next;

    assign mag = dividend[DIV_W-1] ? DIV_W'(-dividend) : DIV_W'(dividend);

    // two restoring steps per cycle
    always_comb
    begin
        r1       = {rem_reg, num_reg[DIV_W-1]};
        ge1      = (r1 >= {1'b0, den_reg});
        r1_next  = ge1 ? DT_W'(r1 - {1'b0, den_reg}) : DT_W'(r1);
        r2       = {r1_next, num_reg[DIV_W-2]};
        ge2      = (r2 >= {1'b0, den_reg});
        rem_next = ge2 ? DT_W'(r2 - {1'b0, den_reg}) : DT_W'(r2);
        num_next = {num_reg[DIV_W-3:0], ge1, ge2};
    end

    // truncated quotient, signed, saturated to 32 bits
    always_comb
    begin
        if (neg_reg)
        begin
            if (num_reg > DIV_W'(64'h8000_0000))
                quot_next = 32'sh8000_0000;
            else
                quot_next = -$signed(num_reg[31:0]);
        end
        else
        begin
            if (num_reg > DIV_W'(64'h7FFF_FFFF))
                quot_next = 32'sh7FFF_FFFF;
            else
                quot_next = $signed(num_reg[31:0]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_ITER);
            end
            else if (busy_reg)
            begin
                if (cnt_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg <= dividend[DIV_W-1];
            num_reg <= mag;
            rem_reg <= '0;
            den_reg <= divisor;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                quot_reg <= quot_next;
            end
            else
            begin
                num_reg <= num_next;
                rem_reg <= rem_next;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== design/erate_ctrl.sv =====
module erate_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  erate_pkg::ctrl_sts_t   sts,
    output erate_pkg::ctrl_cmd_t   cmd
);
    import erate_pkg::*;

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_PREP     = 3'd1;
    localparam logic [2:0] S_VEL_GO   = 3'd2;
    localparam logic [2:0] S_VEL_WAIT = 3'd3;
    localparam logic [2:0] S_ACC_GO   = 3'd4;
    localparam logic [2:0] S_ACC_WAIT = 3'd5;
    localparam logic [2:0] S_REPORT   = 3'd6;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = sts.need_update ? S_VEL_GO : S_REPORT;
            end
            S_VEL_GO:
            begin
                cmd.div_start = 1'b1;
                state_next    = S_VEL_WAIT;
            end
            S_VEL_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.cap_vel = 1'b1;
                    state_next  = S_ACC_GO;
                end
            end
            S_ACC_GO:
            begin
                cmd.div_start   = 1'b1;
                cmd.div_sel_acc = 1'b1;
                state_next      = S_ACC_WAIT;
            end
            S_ACC_WAIT:
            begin
                if (sts.div_done)
                begin
                    cmd.commit = 1'b1;
                    state_next = S_REPORT;
                end
            end
            S_REPORT:
            begin
                if (sts.out_free)
                begin
                    cmd.report = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    assign s_tready = (state_reg == S_IDLE);

endmodule

// ===== design/erate_dp.sv =====
module erate_dp #(
    parameter int COUNT_POLARITY = 1,
    parameter int COUNTER_CENTER = 32768,
    parameter int DT_MAX_MS      = 100,
    parameter int DT_W           = 7
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  erate_pkg::ctrl_cmd_t                  cmd,
    output erate_pkg::ctrl_sts_t                  sts,
    input  logic [erate_pkg::IN_TDATA_W-1:0]      s_tdata,
    input  logic [erate_pkg::IN_TUSER_W-1:0]      s_tuser,
    input  logic                                  cfg_we,
    input  logic [erate_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [erate_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic signed [erate_pkg::DIV_W-1:0]    div_dividend,
    output logic [DT_W-1:0]                       div_divisor,
    input  logic signed [31:0]                    div_quot,
    input  logic                                  div_done,
    input  logic                                  m_tready,
    output logic                                  m_tvalid,
    output logic [erate_pkg::OUT_TDATA_W-1:0]     m_tdata
);
    import erate_pkg::*;

    localparam logic [15:0] CENTER16 = 16'(COUNTER_CENTER);
    localparam logic [31:0] DT_MAX32 = 32'(DT_MAX_MS);
    localparam chan_t CHAN_RST = '{raw: CENTER16, delta: '0, accum: '0, vel: '0,
                                   acc: '0, stamp: '0, sampled: 1'b0};

    // configuration
    logic        ve_reg;
    logic [31:0] zero_off_reg;
    logic [31:0] stale_warn_reg;
    logic [31:0] stale_fault_reg;
    logic [30:0] speed_warn_reg;
    logic [30:0] speed_fault_reg;
    logic [30:0] accel_warn_reg;
    logic [30:0] accel_fault_reg;

    // item and channel state
    logic [1:0]  mode_reg;
    logic [15:0] ctr_reg;
    logic [47:0] vcount_reg;
    logic [31:0] now_reg;
    logic [15:0] prev_ctr_reg;
    chan_t       real_reg;
    chan_t       virt_reg;

    // work registers for one update
    logic               w_virt_reg;
    logic [15:0]        w_raw_reg;
    logic signed [31:0] w_delta_reg;
    logic [47:0]        w_cnt_reg;
    logic [DT_W-1:0]    w_dt_reg;
    logic signed [31:0] vel_reg;

    logic                     m_tvalid_reg;
    logic [OUT_TDATA_W-1:0]   m_tdata_reg;

    logic               w_virt_next;
    chan_t              prep_ch;
    logic [15:0]        sd16;
    logic signed [31:0] sd32;
    logic signed [31:0] real_delta;
    logic [15:0]        w_raw_next;
    logic signed [31:0] w_delta_next;
    logic [47:0]        w_cnt_next;
    logic [31:0]        dt_raw;
    logic [DT_W-1:0]    w_dt_next;
    chan_t              upd_ch;
    logic signed [32:0] vel_diff;
    chan_t              chan_new;
    chan_t              rep_ch;
    logic [31:0]        age;
    logic [31:0]        abs_vel;
    logic [31:0]        abs_acc;
    logic [5:0]         flags;
    logic [47:0]        position;

    assign sts.need_update = ((mode_reg == MODE_SAMPLE) && !ve_reg)
                             || (mode_reg == MODE_SET_VIRTUAL);
    assign sts.div_done    = div_done;
    assign sts.out_free    = !m_tvalid_reg || m_tready;

    // update preparation
    always_comb
    begin
        w_virt_next = (mode_reg == MODE_SET_VIRTUAL);
        prep_ch     = w_virt_next ? virt_reg : real_reg;
        sd16        = ctr_reg - prev_ctr_reg;
        sd32        = 32'(signed'(sd16));
        if (COUNT_POLARITY > 0)
            real_delta = sd32;
        else if (COUNT_POLARITY < 0)
            real_delta = -sd32;
        else
            real_delta = '0;

        if (w_virt_next)
        begin
            w_raw_next   = CENTER16 + vcount_reg[15:0];
            w_delta_next = $signed(vcount_reg[31:0] - virt_reg.accum[31:0]);
            w_cnt_next   = vcount_reg;
        end
        else
        begin
            w_raw_next   = ctr_reg;
            w_delta_next = real_delta;
            w_cnt_next   = real_reg.accum + 48'(real_delta);
        end

        dt_raw = now_reg - prep_ch.stamp;
        if (!prep_ch.sampled || dt_raw == '0)
            w_dt_next = DT_W'(1);
        else if (dt_raw > DT_MAX32)
            w_dt_next = DT_W'(DT_MAX_MS);
        else
            w_dt_next = dt_raw[DT_W-1:0];
    end

    // divider operands
    always_comb
    begin
        upd_ch   = w_virt_reg ? virt_reg : real_reg;
        vel_diff = 33'(vel_reg) - 33'(upd_ch.vel);
        if (cmd.div_sel_acc)
            div_dividend = mul1000(DIV_W'(vel_diff));
        else
            div_dividend = mul1000(DIV_W'(w_delta_reg));
        div_divisor = w_dt_reg;
    end

    always_comb
    begin
        chan_new.raw     = w_raw_reg;
        chan_new.delta   = w_delta_reg;
        chan_new.accum   = w_cnt_reg;
        chan_new.vel     = vel_reg;
        chan_new.acc     = div_quot;
        chan_new.stamp   = now_reg;
        chan_new.sampled = 1'b1;
    end

    // report of the active channel
    always_comb
    begin
        rep_ch   = ve_reg ? virt_reg : real_reg;
        age      = now_reg - rep_ch.stamp;
        abs_vel  = rep_ch.vel[31] ? 32'(-rep_ch.vel) : 32'(rep_ch.vel);
        abs_acc  = rep_ch.acc[31] ? 32'(-rep_ch.acc) : 32'(rep_ch.acc);
        flags[0] = (age >= stale_warn_reg);
        flags[1] = (age >= stale_fault_reg);
        flags[2] = (abs_vel >= {1'b0, speed_warn_reg});
        flags[3] = (abs_vel >= {1'b0, speed_fault_reg});
        flags[4] = (abs_acc >= {1'b0, accel_warn_reg});
        flags[5] = (abs_acc >= {1'b0, accel_fault_reg});
        position = rep_ch.accum - {{16{zero_off_reg[31]}}, zero_off_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve_reg          <= 1'b0;
            zero_off_reg    <= '0;
            stale_warn_reg  <= STALE_WARN_RST;
            stale_fault_reg <= STALE_FAULT_RST;
            speed_warn_reg  <= SPEED_WARN_RST;
            speed_fault_reg <= SPEED_FAULT_RST;
            accel_warn_reg  <= ACCEL_WARN_RST;
            accel_fault_reg <= ACCEL_FAULT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VIRTUAL_ENABLE: ve_reg          <= cfg_data[0];
                REG_ZERO_OFFSET:    zero_off_reg    <= cfg_data;
                REG_STALE_WARN:     stale_warn_reg  <= cfg_data;
                REG_STALE_FAULT:    stale_fault_reg <= cfg_data;
                REG_SPEED_WARN:     speed_warn_reg  <= cfg_data[30:0];
                REG_SPEED_FAULT:    speed_fault_reg <= cfg_data[30:0];
                REG_ACCEL_WARN:     accel_warn_reg  <= cfg_data[30:0];
                REG_ACCEL_FAULT:    accel_fault_reg <= cfg_data[30:0];
                default:            ve_reg          <= ve_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_ctr_reg <= CENTER16;
            real_reg     <= CHAN_RST;
            virt_reg     <= CHAN_RST;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                if (w_virt_reg)
                begin
                    virt_reg <= chan_new;
                end
                else
                begin
                    real_reg     <= chan_new;
                    prev_ctr_reg <= ctr_reg;
                end
            end
            if (cmd.report)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            mode_reg   <= s_tuser;
            ctr_reg    <= s_tdata[15:0];
            vcount_reg <= s_tdata[63:16];
            now_reg    <= s_tdata[95:64];
        end
        if (cmd.prep)
        begin
            w_virt_reg  <= w_virt_next;
            w_raw_reg   <= w_raw_next;
            w_delta_reg <= w_delta_next;
            w_cnt_reg   <= w_cnt_next;
            w_dt_reg    <= w_dt_next;
        end
        if (cmd.cap_vel)
            vel_reg <= div_quot;
        if (cmd.report)
            m_tdata_reg <= {2'b00, flags, age, rep_ch.stamp, rep_ch.acc, rep_ch.vel,
                            position, rep_ch.delta, rep_ch.raw};
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== design/encoder_rate_estimator.sv =====
// Sequence: a report-only transaction is loaded, prepared and reported; one that updates
//   a channel is loaded and prepared, then makes two divider passes (velocity, then
//   acceleration), each of two quotient bits per step, then saturation and capture.
// Acceptance: one transaction at a time; ready again in the cycle after the result is
//   loaded into the output register; the report waits until that register is free.
// Reset: rst_n asynchronous, active low; clears the controller, divider control,
//   channel state and configuration to their defaults.
module encoder_rate_estimator #(
    parameter int COUNT_POLARITY = 1,
    parameter int COUNTER_CENTER = 32768,
    parameter int DT_MAX_MS      = 100
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // counter_value[15:0], virtual_count[63:16], now_ms[95:64]
    input  logic [erate_pkg::IN_TDATA_W-1:0]      s_tdata,
    // mode[1:0]
    input  logic [erate_pkg::IN_TUSER_W-1:0]      s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // raw_ctr[15:0], step_cnt[47:16], position_count[95:48], velocity_cps[127:96],
    // accel_cps2[159:128], sample_time_ms[191:160], age_ms[223:192], flags[229:224]
    output logic [erate_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                  cfg_we,
    input  logic [erate_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [erate_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import erate_pkg::*;

    localparam int DT_W = $clog2(DT_MAX_MS + 1);

    ctrl_cmd_t              cmd;
    ctrl_sts_t              sts;
    logic signed [DIV_W-1:0] div_dividend;
    logic [DT_W-1:0]        div_divisor;
    logic signed [31:0]     div_quot;
    logic                   div_done;
    logic                   div_busy;

    erate_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    erate_dp #(
        .COUNT_POLARITY (COUNT_POLARITY),
        .COUNTER_CENTER (COUNTER_CENTER),
        .DT_MAX_MS      (DT_MAX_MS),
        .DT_W           (DT_W)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .div_dividend (div_dividend),
        .div_divisor  (div_divisor),
        .div_quot     (div_quot),
        .div_done     (div_done),
        .m_tready     (m_tready),
        .m_tvalid     (m_tvalid),
        .m_tdata      (m_tdata)
    );

    erate_div #(
        .DT_W (DT_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .done     (div_done),
        .quot     (div_quot)
    );

`ifndef SYNTHESIS
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("transaction accepted while another is in flight");

    a_div_idle_start: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |-> !div_busy)
        else $error("divider started while busy");

    a_div_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> !div_busy)
        else $error("divider done while still busy");

    a_out_from_report: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(cmd.report))
        else $error("result shown without a report");
`endif

endmodule

// ===== tb/sv/encoder_rate_estimator_tb.sv =====
module encoder_rate_estimator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int COUNT_POLARITY = 1;
    localparam int COUNTER_CENTER = 32768;
    localparam int DT_MAX_MS      = 100;

    localparam int SETTLE_CYC     = 60;
    localparam int N_PHASES       = 8;
    localparam int PHASE_ITEMS    = 200;
    localparam int HOLD_AT        = 300;
    localparam int HOLD_LEN       = 600;
    localparam int WATCHDOG_LIMIT = 4000;

    localparam logic [1:0] MODE_REPORT = 2'd2;
    localparam logic [1:0] MODE_SPARE  = 2'd3;

    localparam longint S32_MAX = 64'sd2147483647;
    localparam longint S32_MIN = -64'sd2147483648;

    // first member sits in the top bits, so raw lands in [15:0] as on m_tdata
    typedef struct packed {
        logic [5:0]  flags;
        logic [31:0] age;
        logic [31:0] stamp;
        logic [31:0] acc;
        logic [31:0] vel;
        logic [47:0] pos;
        logic [31:0] delta;
        logic [15:0] raw;
    } report_t;

    typedef struct packed {
        logic [15:0] raw;
        logic [31:0] delta;
        logic [47:0] cnt;
        logic [31:0] vel;
        logic [31:0] acc;
        logic [31:0] stamp;
        logic        seen;
    } track_t;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        row_kind_t   kind;
        logic [1:0]  mode;
        logic [15:0] ctr;
        logic [47:0] vc;
        logic [31:0] now;
        logic [2:0]  idx;
        logic [31:0] val;
        logic        typed;
        report_t     rep;
    } row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [95:0] s_tdata = '0;
    logic [1:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [231:0] m_tdata;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data = '0;

    // predictor state and register copy
    track_t      trk [2];
    logic [15:0] prev_ctr;
    logic        venable;
    logic [31:0] zoff, stale_w, stale_f;
    logic [30:0] spd_w, spd_f, acc_w, acc_f;

    report_t     reports_due [$];
    row_t        plan [$];

    int n_err = 0;
    int n_checked = 0;
    int n_writes = 0;
    int n_noise = 0;
    int n_mode [4] = '{0, 0, 0, 0};
    int idle_cyc = 0;

    encoder_rate_estimator #(
        .COUNT_POLARITY(COUNT_POLARITY),
        .COUNTER_CENTER(COUNTER_CENTER),
        .DT_MAX_MS     (DT_MAX_MS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic void reset_estimator();
        venable  = 1'b0;
        zoff     = '0;
        stale_w  = erate_pkg::STALE_WARN_RST;
        stale_f  = erate_pkg::STALE_FAULT_RST;
        spd_w    = erate_pkg::SPEED_WARN_RST;
        spd_f    = erate_pkg::SPEED_FAULT_RST;
        acc_w    = erate_pkg::ACCEL_WARN_RST;
        acc_f    = erate_pkg::ACCEL_FAULT_RST;
        prev_ctr = 16'(COUNTER_CENTER);
        for (int c = 0; c < 2; c++)
        begin
            trk[c]     = '0;
            trk[c].raw = 16'(COUNTER_CENTER);
        end
    endfunction

    function automatic void apply_reg(input logic [2:0] idx, input logic [31:0] val);
        case (idx)
            erate_pkg::REG_VIRTUAL_ENABLE: venable = val[0];
            erate_pkg::REG_ZERO_OFFSET:    zoff    = val;
            erate_pkg::REG_STALE_WARN:     stale_w = val;
            erate_pkg::REG_STALE_FAULT:    stale_f = val;
            erate_pkg::REG_SPEED_WARN:     spd_w   = val[30:0];
            erate_pkg::REG_SPEED_FAULT:    spd_f   = val[30:0];
            erate_pkg::REG_ACCEL_WARN:     acc_w   = val[30:0];
            default:                       acc_f   = val[30:0];
        endcase
    endfunction

    function automatic longint sat32(input longint x);
        if (x > S32_MAX)
            return S32_MAX;
        if (x < S32_MIN)
            return S32_MIN;
        return x;
    endfunction

    function automatic void update_track(input int c, input logic [15:0] raw,
                                         input longint delta, input logic [47:0] cnt,
                                         input logic [31:0] now);
        longint      dt;
        longint      v;
        longint      a;
        logic [31:0] gap;
        dt = 1;
        if (trk[c].seen)
        begin
            gap = now - trk[c].stamp;
            if (gap == 32'd0)
                dt = 1;
            else if (gap > 32'(DT_MAX_MS))
                dt = DT_MAX_MS;
            else
                dt = longint'(gap);
        end
        v = sat32((delta * 1000) / dt);
        a = sat32(((v - longint'($signed(trk[c].vel))) * 1000) / dt);
        trk[c].raw   = raw;
        trk[c].delta = delta[31:0];
        trk[c].cnt   = cnt;
        trk[c].vel   = v[31:0];
        trk[c].acc   = a[31:0];
        trk[c].stamp = now;
        trk[c].seen  = 1'b1;
    endfunction

    function automatic report_t estimate_report(input logic [1:0] mode, input logic [15:0] ctr,
                                                input logic [47:0] vc, input logic [31:0] now);
        report_t     r;
        logic [15:0] d16;
        logic [31:0] d32;
        logic [47:0] cnt;
        longint      delta;
        longint      av;
        longint      aa;
        int          c;
        if (mode == erate_pkg::MODE_SAMPLE && !venable)
        begin
            d16      = ctr - prev_ctr;
            delta    = longint'($signed(d16)) * COUNT_POLARITY;
            cnt      = trk[0].cnt + delta[47:0];
            prev_ctr = ctr;
            update_track(0, ctr, delta, cnt, now);
        end
        else if (mode == erate_pkg::MODE_SET_VIRTUAL)
        begin
            d32 = vc[31:0] - trk[1].cnt[31:0];
            update_track(1, vc[15:0] + 16'(COUNTER_CENTER), longint'($signed(d32)), vc, now);
        end
        c = venable ? 1 : 0;
        r.raw   = trk[c].raw;
        r.delta = trk[c].delta;
        r.pos   = trk[c].cnt - {{16{zoff[31]}}, zoff};
        r.vel   = trk[c].vel;
        r.acc   = trk[c].acc;
        r.stamp = trk[c].stamp;
        r.age   = now - trk[c].stamp;
        av = longint'($signed(trk[c].vel));
        aa = longint'($signed(trk[c].acc));
        if (av < 0)
            av = -av;
        if (aa < 0)
            aa = -aa;
        r.flags = {aa >= longint'(acc_f), aa >= longint'(acc_w),
                   av >= longint'(spd_f), av >= longint'(spd_w),
                   r.age >= stale_f, r.age >= stale_w};
        return r;
    endfunction

    function automatic report_t known(input logic [15:0] raw, input logic [31:0] delta,
                                      input logic [47:0] pos, input logic [31:0] vel,
                                      input logic [31:0] acc, input logic [31:0] stamp,
                                      input logic [31:0] age, input logic [5:0] flags);
        report_t r;
        r.raw   = raw;
        r.delta = delta;
        r.pos   = pos;
        r.vel   = vel;
        r.acc   = acc;
        r.stamp = stamp;
        r.age   = age;
        r.flags = flags;
        return r;
    endfunction

    function automatic void add_item(input logic [1:0] mode, input logic [15:0] ctr,
                                     input logic [47:0] vc, input logic [31:0] now,
                                     input bit typed = 1'b0, input report_t rep = '0);
        row_t r;
        r       = '0;
        r.kind  = ROW_ITEM;
        r.mode  = mode;
        r.ctr   = ctr;
        r.vc    = vc;
        r.now   = now;
        r.typed = typed;
        r.rep   = rep;
        plan.push_back(r);
    endfunction

    function automatic void add_reg(input logic [2:0] idx, input logic [31:0] val);
        row_t r;
        r      = '0;
        r.kind = ROW_REG;
        r.idx  = idx;
        r.val  = val;
        plan.push_back(r);
    endfunction

    function automatic logic [31:0] pick_val(input logic [31:0] dflt, input logic [31:0] top,
                                             input int unsigned span);
        case ($urandom_range(0, 7))
            0:       return 32'd0;
            1:       return top;
            2:       return dflt;
            3:       return $urandom;
            default: return $urandom_range(0, span);
        endcase
    endfunction

    task automatic send_item(input logic [1:0] mode, input logic [15:0] ctr,
                             input logic [47:0] vc, input logic [31:0] now,
                             input bit typed, input report_t rep);
        report_t r;
        s_tvalid <= 1'b1;
        s_tuser  <= mode;
        s_tdata  <= {now, vc, ctr};
        do
            @(posedge clk);
        while (!s_tready);
        r = estimate_report(mode, ctr, vc, now);
        reports_due.push_back(typed ? rep : r);
        n_mode[mode]++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        apply_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
        n_writes++;
    endtask

    task automatic settle();
        while (reports_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // receiver: ready pattern, one long hold-off, result check
    initial
    begin : rx_proc
        report_t got;
        report_t want;
        int      style;
        int      span;
        int      hold_left;
        int      cyc;
        bit      held;
        bit      rdy;
        held      = 1'b0;
        hold_left = 0;
        cyc       = 0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            style = $urandom_range(0, 3);
            span  = $urandom_range(16, 160);
            repeat (span)
            begin
                @(posedge clk);
                if (m_tvalid && m_tready)
                begin
                    got = m_tdata[229:0];
                    n_checked++;
                    if (reports_due.size() == 0)
                    begin
                        n_err++;
                        if (n_err <= 10)
                            $display("result with no pending transaction: %h", got);
                    end
                    else
                    begin
                        want = reports_due.pop_front();
                        if (got !== want)
                        begin
                            n_err++;
                            if (n_err <= 10)
                            begin
                                $display("mismatch %0d exp raw=%h delta=%h pos=%h vel=%h acc=%h stamp=%h age=%h flags=%b",
                                         n_err, want.raw, want.delta, want.pos, want.vel,
                                         want.acc, want.stamp, want.age, want.flags);
                                $display("mismatch %0d got raw=%h delta=%h pos=%h vel=%h acc=%h stamp=%h age=%h flags=%b",
                                         n_err, got.raw, got.delta, got.pos, got.vel,
                                         got.acc, got.stamp, got.age, got.flags);
                            end
                        end
                    end
                end
                if (hold_left > 0)
                begin
                    hold_left--;
                    rdy = 1'b0;
                end
                else if (!held && n_checked >= HOLD_AT)
                begin
                    held      = 1'b1;
                    hold_left = HOLD_LEN - 1;
                    rdy       = 1'b0;
                end
                else
                begin
                    case (style)
                        0:       rdy = 1'b1;
                        1:       rdy = 1'($urandom_range(0, 1));
                        2:       rdy = ($urandom_range(0, 7) == 0);
                        default: rdy = (cyc % 3 == 0);
                    endcase
                end
                cyc++;
                m_tready <= rdy;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cyc <= 0;
        else if (idle_cyc >= WATCHDOG_LIMIT)
        begin
            $display("no transaction for %0d cycles, %0d results pending",
                     idle_cyc, reports_due.size());
            $display("encoder_rate_estimator test failed");
            $finish;
        end
        else
            idle_cyc <= idle_cyc + 1;
    end

    initial
    begin : stim_proc
        logic [1:0]  mode;
        logic [15:0] ctr;
        logic [47:0] vc;
        logic [31:0] now;
        logic [31:0] tick;
        logic [15:0] ctr_cur;
        logic [47:0] vcur;
        int          gap;
        int          burst;
        int          sel;
        int          t;

        reset_estimator();

        // after reset, first real sample, stale report
        add_item(MODE_REPORT, 16'h0000, 48'h0, 32'd5, 1'b1,
                 known(16'h8000, 32'd0, 48'd0, 32'd0, 32'd0, 32'd0, 32'd5, 6'b000000));
        add_item(erate_pkg::MODE_SAMPLE, 16'h8001, 48'h0, 32'd10, 1'b1,
                 known(16'h8001, 32'd1, 48'd1, 32'd1000, 32'd1000000, 32'd10, 32'd0,
                       6'b000000));
        add_item(MODE_REPORT, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 32'd130, 1'b1,
                 known(16'h8001, 32'd1, 48'd1, 32'd1000, 32'd1000000, 32'd10, 32'd120,
                       6'b000011));
        // counter wrap at both signed extremes, zero dt, clamped dt, tick wrap
        add_item(erate_pkg::MODE_SAMPLE, 16'h0000, 48'h0, 32'd131);
        add_item(erate_pkg::MODE_SAMPLE, 16'h8000, 48'h0, 32'd131);
        add_item(erate_pkg::MODE_SAMPLE, 16'hFFFF, 48'h0, 32'hFFFF_FFFF);
        add_item(erate_pkg::MODE_SAMPLE, 16'h0000, 48'h0, 32'd2);
        add_item(MODE_SPARE, 16'd1234, 48'h1234_5678_9ABC, 32'd10);
        // virtual set while the real channel is active
        add_item(erate_pkg::MODE_SET_VIRTUAL, 16'h5555, 48'h7FFF_FFFF_FFFF, 32'd50);
        add_reg(erate_pkg::REG_VIRTUAL_ENABLE, 32'd1);
        add_item(MODE_REPORT, 16'h0, 48'h0, 32'd60);
        // real sample is blocked
        add_item(erate_pkg::MODE_SAMPLE, 16'd5, 48'h0, 32'd61);
        add_reg(erate_pkg::REG_ZERO_OFFSET, 32'h8000_0000);
        add_item(MODE_REPORT, 16'h0, 48'h0, 32'd62);
        add_item(erate_pkg::MODE_SET_VIRTUAL, 16'hAAAA, 48'h8000_0000_0000, 32'd63);
        add_reg(erate_pkg::REG_ZERO_OFFSET, 32'h7FFF_FFFF);
        add_item(MODE_REPORT, 16'h0, 48'h0, 32'd64);
        for (int j = erate_pkg::REG_STALE_WARN; j <= erate_pkg::REG_ACCEL_FAULT; j++)
            add_reg(3'(j), 32'd0);
        add_item(MODE_REPORT, 16'h0, 48'h0, 32'd64);
        for (int j = erate_pkg::REG_STALE_WARN; j <= erate_pkg::REG_ACCEL_FAULT; j++)
            add_reg(3'(j), 32'hFFFF_FFFF);
        add_item(erate_pkg::MODE_SET_VIRTUAL, 16'h0, 48'd100, 32'd70);
        add_item(MODE_REPORT, 16'h0, 48'h0, 32'd69);
        add_reg(erate_pkg::REG_VIRTUAL_ENABLE, 32'd0);
        add_item(erate_pkg::MODE_SAMPLE, 16'h7FFF, 48'h0, 32'd80);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k])
        begin
            if (plan[k].kind == ROW_REG)
            begin
                s_tvalid <= 1'b0;
                settle();
                write_reg(plan[k].idx, plan[k].val);
            end
            else
            begin
                send_item(plan[k].mode, plan[k].ctr, plan[k].vc, plan[k].now,
                          plan[k].typed, plan[k].rep);
                gap = $urandom_range(0, 2);
                if (gap > 0)
                begin
                    s_tvalid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end

        tick    = 32'd100;
        ctr_cur = 16'h7FFF;
        vcur    = 48'd100;
        for (int p = 0; p < N_PHASES; p++)
        begin
            s_tvalid <= 1'b0;
            settle();
            write_reg(erate_pkg::REG_VIRTUAL_ENABLE, 32'(p % 2));
            write_reg(erate_pkg::REG_ZERO_OFFSET, pick_val(32'd0, 32'h7FFF_FFFF, 1000));
            write_reg(erate_pkg::REG_STALE_WARN,
                      pick_val(erate_pkg::STALE_WARN_RST, 32'hFFFF_FFFF, 60));
            write_reg(erate_pkg::REG_STALE_FAULT,
                      pick_val(erate_pkg::STALE_FAULT_RST, 32'hFFFF_FFFF, 300));
            write_reg(erate_pkg::REG_SPEED_WARN,
                      pick_val(32'(erate_pkg::SPEED_WARN_RST), 32'h7FFF_FFFF, 300000));
            write_reg(erate_pkg::REG_SPEED_FAULT,
                      pick_val(32'(erate_pkg::SPEED_FAULT_RST), 32'h7FFF_FFFF, 400000));
            write_reg(erate_pkg::REG_ACCEL_WARN,
                      pick_val(32'(erate_pkg::ACCEL_WARN_RST), 32'h7FFF_FFFF, 30000000));
            write_reg(erate_pkg::REG_ACCEL_FAULT,
                      pick_val(32'(erate_pkg::ACCEL_FAULT_RST), 32'h7FFF_FFFF, 40000000));

            burst = $urandom_range(1, 24);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                sel = $urandom_range(0, 99);
                if (sel >= 90)
                begin
                    mode = 2'($urandom_range(0, 3));
                    ctr  = 16'($urandom);
                    vc   = 48'({$urandom, $urandom});
                    now  = $urandom;
                    n_noise++;
                end
                else
                begin
                    t = $urandom_range(0, 99);
                    if (t < 80)
                        tick = tick + 32'($urandom_range(0, 3));
                    else if (t < 95)
                        tick = tick + 32'($urandom_range(4, 40));
                    else
                        tick = tick + 32'($urandom_range(90, 400));
                    now = tick;
                    if (sel < 60)
                        mode = venable ? erate_pkg::MODE_SET_VIRTUAL : erate_pkg::MODE_SAMPLE;
                    else if (sel < 72)
                        mode = venable ? erate_pkg::MODE_SAMPLE : erate_pkg::MODE_SET_VIRTUAL;
                    else
                        mode = ($urandom_range(0, 3) == 0) ? MODE_SPARE : MODE_REPORT;
                    if ($urandom_range(0, 19) == 0)
                        ctr_cur = 16'($urandom_range(0, 65535));
                    else
                        ctr_cur = ctr_cur + 16'(int'($urandom_range(0, 400)) - 200);
                    if ($urandom_range(0, 19) == 0)
                        vcur = 48'({$urandom, $urandom});
                    else
                        vcur = vcur + 48'(longint'(int'($urandom_range(0, 4000)) - 2000));
                    ctr = ctr_cur;
                    vc  = vcur;
                end
                send_item(mode, ctr, vc, now, 1'b0, '0);
                burst--;
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 24);
                    gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                    if (gap > 0)
                    begin
                        s_tvalid <= 1'b0;
                        repeat (gap) @(posedge clk);
                    end
                end
            end
        end

        s_tvalid <= 1'b0;
        settle();
        $display("%0d transactions: %0d sample, %0d set virtual, %0d report, %0d spare mode, %0d noise",
                 n_mode[0] + n_mode[1] + n_mode[2] + n_mode[3],
                 n_mode[0], n_mode[1], n_mode[2], n_mode[3], n_noise);
        $display("%0d results checked, %0d register writes, %0d mismatches",
                 n_checked, n_writes, n_err);
        if (n_err == 0)
            $display("encoder_rate_estimator test passed");
        else
            $display("encoder_rate_estimator test failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/erate_pkg.sv
design/erate_div.sv
design/erate_ctrl.sv
design/erate_dp.sv
design/encoder_rate_estimator.sv
tb/sv/encoder_rate_estimator_tb.sv
